>>> rtl/fir16_pkg.sv
// ----------------------------------------------------------------------------
// fir16_pkg
// Shared types and constants for the 16-bit sample FIR filter: request
// payloads, configuration register indexes and the control bundle that the
// sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fir16_pkg;

  // Default sizing
  localparam int FIR16_MAX_TAPS       = 64;
  localparam int FIR16_COEF_FRAC_BITS = 15;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int TAPREG_W  = 7;
  localparam int CIDX_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_VALUE = 2'd2;

  // Input request payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } sample_item_t;

  // Output request payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       block_end_out;
  } result_item_t;

  // Operand tags from the sequencer to the MAC unit
  typedef struct packed {
    logic op_valid;
    logic op_first;
    logic op_last;
  } mac_ctl_t;

endpackage

>>> rtl/fir16_mac.sv
// ----------------------------------------------------------------------------
// fir16_mac
// Shared multiply-accumulate unit. One coefficient/sample pair per cycle is
// multiplied, registered and summed into a wide accumulator. After the last
// pair the sum is scaled down by the coefficient fraction, truncated toward
// zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module fir16_mac
  import fir16_pkg::*;
#(
  parameter int MAX_TAPS       = FIR16_MAX_TAPS,
  parameter int COEF_FRAC_BITS = FIR16_COEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctl_t                   ctl,
  input  logic signed [COEF_W-1:0]   coef,
  input  logic signed [SAMPLE_W-1:0] smp,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] q
);

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

  localparam logic signed [ACC_W-1:0] BIAS   = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_first;
  logic                     p_last;
  logic signed [ACC_W-1:0]  acc;
  logic                     a_last;
  logic signed [ACC_W-1:0]  biased;
  logic                     r_valid;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [ACC_W-1:0]  prod_ext;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= ctl.op_valid;
    end
    prod    <= coef * smp;
    p_first <= ctl.op_first;
    p_last  <= ctl.op_last;
  end

  assign prod_ext = ACC_W'(prod);

  // Accumulate stage; the first pair restarts the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      a_last <= 1'b0;
    end else begin
      a_last <= p_valid & p_last;
    end
    if (p_valid) begin
      acc <= p_first ? prod_ext : acc + prod_ext;
    end
  end

  // Bias negative sums so the shift truncates toward zero
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= a_last;
    end
    if (a_last) begin
      biased <= acc[ACC_W-1] ? acc + BIAS : acc;
    end
  end

  assign shifted = biased >>> COEF_FRAC_BITS;

  // Scale and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_valid;
    end
    if (r_valid) begin
      if (shifted > SAT_HI) begin
        q <= 16'sh7fff;
      end else if (shifted < SAT_LO) begin
        q <= 16'sh8000;
      end else begin
        q <= shifted[SAMPLE_W-1:0];
      end
    end
  end

endmodule

>>> rtl/fir_filter_16bit_samples_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_16bit_samples_unit
// Direct-form FIR filter on signed 16-bit samples with Q2.15 coefficients.
// Samples go into a circular delay line; a sequencer walks the taps and feeds
// one shared multiply-accumulate unit, newest sample against tap 0.
// ----------------------------------------------------------------------------
// One sample is filtered at a time: sample_stall is high from the accepted
// request until the result is handed to the output register, as the single
// MAC unit takes one tap per cycle plus its pipeline drain.
// Reset (rst, synchronous): tap_count 1, coefficients read as zero, delay
// line empty, no result pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fir_filter_16bit_samples_unit
  import fir16_pkg::*;
#(
  parameter int MAX_TAPS       = FIR16_MAX_TAPS,
  parameter int COEF_FRAC_BITS = FIR16_COEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_item_t         sample_data,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_item_t         result_data,
  // configuration port
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_DAT_W-1:0] wr_data
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [CW-1:0]              tap_n;
  logic [CW-1:0]              fill;
  logic [AW-1:0]              pos;
  logic [AW-1:0]              k;
  logic [AW-1:0]              idx;
  logic [CIDX_W-1:0]          coef_index;
  logic                       blk;

  logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] dly_mem  [MAX_TAPS];
  logic [MAX_TAPS-1:0]        coef_vld;

  logic signed [COEF_W-1:0]   coef_rd;
  logic signed [SAMPLE_W-1:0] dly_rd;
  logic                       coef_ok;
  logic                       dly_ok;
  mac_ctl_t                   rd_ctl;

  logic                       accept;
  logic                       k_last;
  logic                       tap_wr;
  logic                       coef_wr;
  logic [TAPREG_W-1:0]        tap_raw;
  logic [CW-1:0]              tap_clamped;
  logic                       mac_done;
  logic signed [SAMPLE_W-1:0] mac_q;
  logic                       out_free;

  assign accept   = sample_valid & ~sample_stall;
  assign k_last   = (CW'(k) == tap_n - CW'(1));
  assign out_free = ~result_valid | ~result_stall;
  assign sample_stall = (state != S_IDLE);

  // Configuration decode
  assign tap_wr  = wr_en & (wr_index == REG_TAP_COUNT);
  assign coef_wr = wr_en & (wr_index == REG_COEF_VALUE) & (32'(coef_index) < MAX_TAPS);
  assign tap_raw = wr_data[TAPREG_W-1:0];

  always_comb begin
    if (tap_raw == '0) begin
      tap_clamped = CW'(1);
    end else if (32'(tap_raw) > MAX_TAPS) begin
      tap_clamped = CW'(MAX_TAPS);
    end else begin
      tap_clamped = CW'(tap_raw);
    end
  end

  // Configuration registers and coefficient valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_n      <= CW'(1);
      coef_index <= '0;
      coef_vld   <= '0;
    end else begin
      if (tap_wr) begin
        tap_n <= tap_clamped;
      end
      if (wr_en && wr_index == REG_COEF_INDEX) begin
        coef_index <= wr_data[CIDX_W-1:0];
      end
      if (coef_wr) begin
        coef_vld[AW'(coef_index)] <= 1'b1;
      end
    end
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[AW'(coef_index)] <= wr_data;
    end
    coef_rd <= coef_mem[k];
  end

  // Delay line; entries at or beyond the fill count read as zero
  always_ff @(posedge clk) begin
    if (accept) begin
      dly_mem[pos] <= sample_data.sample;
    end
    dly_rd <= dly_mem[idx];
  end

  // Write position and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      fill <= '0;
    end else if (tap_wr) begin
      pos  <= '0;
      fill <= '0;
    end else if (accept) begin
      pos <= (CW'(pos) == tap_n - CW'(1)) ? '0 : pos + AW'(1);
      if (fill < tap_n) begin
        fill <= fill + CW'(1);
      end
    end
  end

  // Tap walk: k counts up, idx walks back from the newest sample
  always_ff @(posedge clk) begin
    if (accept) begin
      k   <= '0;
      idx <= pos;
      blk <= sample_data.block_end;
    end else if (state == S_RUN) begin
      k   <= k + AW'(1);
      idx <= (idx == '0) ? AW'(tap_n - CW'(1)) : idx - AW'(1);
    end
  end

  // Read tags and validity, aligned with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
    end else begin
      rd_ctl.op_valid <= (state == S_RUN);
      rd_ctl.op_first <= (state == S_RUN) & (k == '0);
      rd_ctl.op_last  <= (state == S_RUN) & k_last;
    end
    coef_ok <= coef_vld[k];
    dly_ok  <= (CW'(idx) < fill);
  end

  fir16_mac #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rd_ctl),
    .coef (coef_ok ? coef_rd : '0),
    .smp  (dly_ok ? dly_rd : '0),
    .done (mac_done),
    .q    (mac_q)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (mac_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (state == S_DONE && out_free) begin
      result_data.filtered      <= mac_q;
      result_data.block_end_out <= blk;
    end
  end

  // Checks
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(pos) < tap_n)
    else $error("write position beyond tap count");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= tap_n)
    else $error("fill count exceeds tap count");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == S_DRAIN)
    else $error("MAC result outside drain");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RUN && k == '0)
    else $error("accepted sample did not start tap walk");

endmodule
